// ===== rtl/bwes_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwes_pkg
// Shared constants, types and codes of the beat window event sequencer.
// ----------------------------------------------------------------------------
package bwes_pkg;

  localparam int MaxEvents            = 16;
  localparam int PositionFractionBits = 16;
  localparam int PosBits              = 16 + PositionFractionBits;
  localparam logic [31:0] PosMask     = 32'hFFFF_FFFF >> (32 - PosBits);
  localparam int MaxResults           = 32;
  localparam int IdxW                 = (MaxEvents > 1) ? $clog2(MaxEvents) : 1;
  localparam int UsedW                = $clog2(MaxEvents + 1);
  localparam int MsgCntW              = $clog2(MaxResults + 1);

  localparam logic [7:0] NoteOffOffset = 8'd200;
  localparam logic [3:0] StatusNoteOff = 4'h8;
  localparam logic [3:0] StatusNoteOn  = 4'h9;
  localparam logic [3:0] StatusCtrl    = 4'hB;

  localparam logic OpLoad     = 1'b0;
  localparam logic OpPosition = 1'b1;

  localparam logic CfgPatternEnabled = 1'b0;
  localparam logic CfgEventCount     = 1'b1;

  typedef struct packed {
    logic [31:0] beat;
    logic        is_ctrl;
    logic [4:0]  channel;
    logic [6:0]  number;
    logic [6:0]  amount;
  } entry_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [7:0] offset;
  } msg_t;

  typedef enum logic [2:0] {
    StIdle,
    StFetch,
    StCheck,
    StOff,
    StFlush
  } state_e;

  typedef struct packed {
    logic load;
    logic begin_scan;
    logic clear_prev;
    logic fetch;
    logic push_on;
    logic push_ctrl;
    logic push_off;
    logic advance;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic is_ctrl;
    logic last_entry;
    logic enabled;
    logic used_zero;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/bwes_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwes_ctrl
// Controller: decodes items and steps the table scan one entry at a time.
// ----------------------------------------------------------------------------
module bwes_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          operation_i,
  input  wire logic          position_present_i,
  input  wire logic          playing_i,
  input  wire logic          position_known_i,
  input  wire bwes_pkg::sts_t sts_i,
  output bwes_pkg::cmd_t     cmd_o,
  output logic               busy_o
);
  import bwes_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i && operation_i == OpPosition && position_present_i &&
            sts_i.enabled && playing_i && position_known_i) begin
          state_d = sts_i.used_zero ? StFlush : StFetch;
        end
      end
      StFetch: state_d = StCheck;
      StCheck: begin
        if (sts_i.hit && !sts_i.is_ctrl) begin
          state_d = StOff;
        end else begin
          state_d = sts_i.last_entry ? StFlush : StFetch;
        end
      end
      StOff:   state_d = sts_i.last_entry ? StFlush : StFetch;
      StFlush: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (start_i) begin
          if (operation_i == OpLoad) begin
            cmd_o.load = 1'b1;
          end else if (position_present_i && sts_i.enabled) begin
            if (!playing_i) begin
              cmd_o.clear_prev = 1'b1;
            end else if (position_known_i) begin
              cmd_o.begin_scan = 1'b1;
            end
          end
        end
      end
      StFetch: cmd_o.fetch = 1'b1;
      StCheck: begin
        if (sts_i.hit) begin
          cmd_o.push_ctrl = sts_i.is_ctrl;
          cmd_o.push_on   = !sts_i.is_ctrl;
        end
        cmd_o.advance = !sts_i.hit || sts_i.is_ctrl;
      end
      StOff: begin
        cmd_o.push_off = 1'b1;
        cmd_o.advance  = 1'b1;
      end
      StFlush: cmd_o.flush = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bwes_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwes_datapath
// Datapath: event table, window compare, message hold and result beat regs.
// ----------------------------------------------------------------------------
module bwes_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bwes_pkg::cmd_t cmd_i,
  output bwes_pkg::sts_t      sts_o,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_index_i,
  input  wire logic [4:0]     cfg_data_i,
  input  wire logic [3:0]     entry_index_i,
  input  wire logic [31:0]    entry_beat_i,
  input  wire logic           entry_is_controller_i,
  input  wire logic [4:0]     entry_channel_i,
  input  wire logic [6:0]     entry_number_i,
  input  wire logic [6:0]     entry_amount_i,
  input  wire logic [31:0]    position_i,
  output logic                result_valid_o,
  output logic [7:0]          status_byte_o,
  output logic [6:0]          data_first_o,
  output logic [6:0]          data_second_o,
  output logic [7:0]          sample_offset_o,
  output logic                last_of_run_o
);
  import bwes_pkg::*;

  entry_t             table_mem [MaxEvents];
  entry_t             rd_q;
  logic               enabled_q;
  logic [4:0]         count_q;
  logic [31:0]        prev_q;
  logic [31:0]        cur_q;
  logic [IdxW-1:0]    idx_q;
  logic [UsedW-1:0]   used_q;
  logic [UsedW-1:0]   used_sat;
  logic [MsgCntW-1:0] cnt_q;
  msg_t               held_q;
  logic               held_v_q;
  msg_t               out_q;
  logic               out_v_q;
  logic               out_last_q;
  msg_t               new_msg;
  logic [3:0]         ch;
  logic               push;
  logic               can_push;
  logic               wrap;
  logic               ge_prev;
  logic               lt_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      count_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPatternEnabled: enabled_q <= cfg_data_i[0];
        CfgEventCount:     count_q   <= cfg_data_i;
        default:           enabled_q <= enabled_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (int'(entry_index_i) < MaxEvents)) begin
      table_mem[IdxW'(entry_index_i)] <= '{
        beat:    entry_beat_i & PosMask,
        is_ctrl: entry_is_controller_i,
        channel: entry_channel_i,
        number:  entry_number_i,
        amount:  entry_amount_i
      };
    end
    if (cmd_i.fetch) begin
      rd_q <= table_mem[idx_q];
    end
  end

  assign used_sat = (int'(count_q) > MaxEvents) ? UsedW'(MaxEvents) : UsedW'(count_q);

  assign wrap    = cur_q < prev_q;
  assign ge_prev = rd_q.beat >= prev_q;
  assign lt_cur  = rd_q.beat < cur_q;

  assign sts_o.hit        = wrap ? (ge_prev || lt_cur) : (ge_prev && lt_cur);
  assign sts_o.is_ctrl    = rd_q.is_ctrl;
  assign sts_o.last_entry = ((UsedW'(idx_q) + UsedW'(1)) == used_q);
  assign sts_o.enabled    = enabled_q;
  assign sts_o.used_zero  = (used_sat == '0);

  assign ch = 4'(rd_q.channel - 5'd1);

  always_comb begin
    new_msg.data_first  = rd_q.number;
    new_msg.data_second = rd_q.amount;
    new_msg.offset      = 8'd0;
    new_msg.status      = {StatusNoteOn, ch};
    if (cmd_i.push_ctrl) begin
      new_msg.status = {StatusCtrl, ch};
    end else if (cmd_i.push_off) begin
      new_msg.status      = {StatusNoteOff, ch};
      new_msg.data_second = 7'd0;
      new_msg.offset      = NoteOffOffset;
    end
  end

  assign push     = cmd_i.push_on || cmd_i.push_ctrl || cmd_i.push_off;
  assign can_push = (int'(cnt_q) < MaxResults);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      cur_q    <= '0;
      idx_q    <= '0;
      used_q   <= '0;
      cnt_q    <= '0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      out_v_q <= 1'b0;
      if (cmd_i.clear_prev) begin
        prev_q <= '0;
      end
      if (cmd_i.begin_scan) begin
        cur_q    <= position_i & PosMask;
        used_q   <= used_sat;
        idx_q    <= '0;
        cnt_q    <= '0;
        held_v_q <= 1'b0;
      end
      if (cmd_i.advance) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (push && can_push) begin
        out_v_q  <= held_v_q;
        held_v_q <= 1'b1;
        cnt_q    <= cnt_q + MsgCntW'(1);
      end else if (cmd_i.flush) begin
        out_v_q  <= held_v_q;
        held_v_q <= 1'b0;
        prev_q   <= cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && can_push) begin
      held_q     <= new_msg;
      out_q      <= held_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.flush) begin
      out_q      <= held_q;
      out_last_q <= 1'b1;
    end
  end

  assign result_valid_o  = out_v_q;
  assign status_byte_o   = out_q.status;
  assign data_first_o    = out_q.data_first;
  assign data_second_o   = out_q.data_second;
  assign sample_offset_o = out_q.offset;
  assign last_of_run_o   = out_v_q && out_last_q;

endmodule
`default_nettype wire

// ===== rtl/beat_window_event_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// beat_window_event_sequencer
// Pattern event table scanned against a beat window, emitting raw MIDI beats.
// A position item, when enabled, playing and the position known, scans each
// entry in use, with an extra step per note hit; busy is high meanwhile, and
// the next item is taken when busy drops.
// Each result beat is held until the next one is formed or the scan ends, then
// shows for one cycle; the receiver cannot stall.
// Reset clears the controller, config, counters, valid flags and previous
// position; table, read and message registers are undefined until written.
// ----------------------------------------------------------------------------
module beat_window_event_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [4:0]  cfg_data_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation_i,
  input  wire logic [3:0]  entry_index_i,
  input  wire logic [31:0] entry_beat_i,
  input  wire logic        entry_is_controller_i,
  input  wire logic [4:0]  entry_channel_i,
  input  wire logic [6:0]  entry_number_i,
  input  wire logic [6:0]  entry_amount_i,
  input  wire logic        position_present_i,
  input  wire logic        playing_i,
  input  wire logic        position_known_i,
  input  wire logic [31:0] position_i,
  output logic             result_valid_o,
  output logic [7:0]       status_byte_o,
  output logic [6:0]       data_first_o,
  output logic [6:0]       data_second_o,
  output logic [7:0]       sample_offset_o,
  output logic             last_of_run_o
);
  import bwes_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bwes_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .operation_i        (operation_i),
    .position_present_i (position_present_i),
    .playing_i          (playing_i),
    .position_known_i   (position_known_i),
    .sts_i              (sts),
    .cmd_o              (cmd),
    .busy_o             (busy)
  );

  bwes_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .entry_index_i         (entry_index_i),
    .entry_beat_i          (entry_beat_i),
    .entry_is_controller_i (entry_is_controller_i),
    .entry_channel_i       (entry_channel_i),
    .entry_number_i        (entry_number_i),
    .entry_amount_i        (entry_amount_i),
    .position_i            (position_i),
    .result_valid_o        (result_valid_o),
    .status_byte_o         (status_byte_o),
    .data_first_o          (data_first_o),
    .data_second_o         (data_second_o),
    .sample_offset_o       (sample_offset_o),
    .last_of_run_o         (last_of_run_o)
  );

endmodule
`default_nettype wire

// ===== rtl/bwes_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwes_checker
// Port-level checks of the sequencer's result beats, bound to the top level.
// ----------------------------------------------------------------------------
module bwes_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       operation_i,
  input wire logic       result_valid_o,
  input wire logic [7:0] status_byte_o,
  input wire logic [6:0] data_second_o,
  input wire logic [7:0] sample_offset_o,
  input wire logic       last_of_run_o
);
  import bwes_pkg::*;

  a_last_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_of_run_o |-> result_valid_o)
    else $error("last_of_run without result beat");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_of_run_o) |-> busy)
    else $error("non-final beat while run already finished");

  a_note_off_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_byte_o[7:4] == StatusNoteOff) |->
      (data_second_o == 7'd0 && sample_offset_o == NoteOffOffset))
    else $error("note-off beat with bad velocity or offset");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == OpLoad) |=> !result_valid_o)
    else $error("result beat after load item");

endmodule

bind beat_window_event_sequencer bwes_checker u_bwes_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .operation_i     (operation_i),
  .result_valid_o  (result_valid_o),
  .status_byte_o   (status_byte_o),
  .data_second_o   (data_second_o),
  .sample_offset_o (sample_offset_o),
  .last_of_run_o   (last_of_run_o)
);
`default_nettype wire
